// ----- rtl/tmm_pkg.sv -----
// ----------------------------------------------------------------------------
// tmm_pkg
// Shared types and constants of the top-k multiway merge.
// ----------------------------------------------------------------------------
`default_nettype none

package tmm_pkg;

    localparam int MAX_LISTS_DEF = 8;
    localparam int MAX_K_DEF     = 64;

    localparam int LIST_IDX_W = 3;
    localparam int POS_W      = 6;
    localparam int SCORE_W    = 32;
    localparam int IDENT_W    = 64;
    localparam int RANK_W     = 6;
    localparam int K_W        = 7;
    localparam int LC_W       = 6;
    localparam int LISTS_W    = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_METRIC_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOPK_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIST_COUNT  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PUT
    } tmm_state_t;

    typedef struct packed {
        logic            metric_mode;
        logic [K_W-1:0]  k;
        logic [LC_W-1:0] lc;
    } tmm_merge_cfg_t;

    // True if score a ranks strictly ahead of score b.
    function automatic logic better(input logic metric_mode,
                                    input logic signed [SCORE_W-1:0] a,
                                    input logic signed [SCORE_W-1:0] b);
        logic res;
        if (metric_mode)
        begin
            res = (a > b);
        end
        else
        begin
            res = (a < b);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/tmm_entry_if.sv -----
// ----------------------------------------------------------------------------
// tmm_entry_if
// Input channel: one sorted-list entry per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmm_entry_if;
    logic                                   valid;
    logic                                   ready;
    logic [tmm_pkg::LIST_IDX_W-1:0]         list_index;
    logic [tmm_pkg::POS_W-1:0]              entry_position;
    logic signed [tmm_pkg::SCORE_W-1:0]     distance;
    logic signed [tmm_pkg::IDENT_W-1:0]     label;
    logic                                   last_entry;

    modport source (
        output valid, list_index, entry_position, distance, label, last_entry,
        input  ready
    );

    modport sink (
        input  valid, list_index, entry_position, distance, label, last_entry,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/tmm_result_if.sv -----
// ----------------------------------------------------------------------------
// tmm_result_if
// Output channel: one merged result per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmm_result_if;
    logic                                   valid;
    logic                                   ready;
    logic [tmm_pkg::RANK_W-1:0]             rank;
    logic signed [tmm_pkg::SCORE_W-1:0]     distance_res;
    logic signed [tmm_pkg::IDENT_W-1:0]     label_res;
    logic                                   last_result;

    modport source (
        output valid, rank, distance_res, label_res, last_result,
        input  ready
    );

    modport sink (
        input  valid, rank, distance_res, label_res, last_result,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/tmm_ram.sv -----
// ----------------------------------------------------------------------------
// tmm_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/tmm_merge_ctrl.sv -----
// ----------------------------------------------------------------------------
// tmm_merge_ctrl
// Merge sequencer: scans the list heads through the stores, keeps the best
// candidate, emits it into the output register and advances its head.
// ----------------------------------------------------------------------------
`default_nettype none

module tmm_merge_ctrl #(
    parameter int MAX_LISTS = tmm_pkg::MAX_LISTS_DEF,
    parameter int MAX_K     = tmm_pkg::MAX_K_DEF,
    localparam int LIW      = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1,
    localparam int KPW      = (MAX_K > 1) ? $clog2(MAX_K) : 1,
    localparam int ADDR_W   = LIW + KPW
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire tmm_pkg::tmm_merge_cfg_t                cfg,
    output logic                                        busy,
    output logic [ADDR_W-1:0]                           rd_addr,
    input  wire logic signed [tmm_pkg::SCORE_W-1:0]     rd_score,
    input  wire logic signed [tmm_pkg::IDENT_W-1:0]     rd_ident,
    tmm_result_if.source                                result
);

    localparam int NHEAD = 1 << LIW;

    tmm_pkg::tmm_state_t                state_reg, state_next;
    tmm_pkg::tmm_merge_cfg_t            cfg_reg, cfg_next;
    logic [LIW-1:0]                     scan_reg, scan_next;
    logic                               cmp_vld_reg, cmp_vld_next;
    logic                               cmp_use_reg, cmp_use_next;
    logic [LIW-1:0]                     cmp_list_reg, cmp_list_next;
    logic                               found_reg, found_next;
    logic [LIW-1:0]                     best_list_reg, best_list_next;
    logic signed [tmm_pkg::SCORE_W-1:0] best_score_reg, best_score_next;
    logic signed [tmm_pkg::IDENT_W-1:0] best_ident_reg, best_ident_next;
    logic [tmm_pkg::K_W-1:0]            emit_reg, emit_next;
    logic [tmm_pkg::K_W-1:0]            head_reg [NHEAD];
    logic [tmm_pkg::K_W-1:0]            head_next [NHEAD];
    logic                               out_vld_reg, out_vld_next;
    logic [tmm_pkg::RANK_W-1:0]         out_rank_reg, out_rank_next;
    logic signed [tmm_pkg::SCORE_W-1:0] out_score_reg, out_score_next;
    logic signed [tmm_pkg::IDENT_W-1:0] out_ident_reg, out_ident_next;
    logic                               out_last_reg, out_last_next;
    logic                               is_last;
    logic                               out_free;

    assign busy    = (state_reg != tmm_pkg::ST_IDLE);
    assign rd_addr = {scan_reg, head_reg[scan_reg][KPW-1:0]};
    assign is_last = ((emit_reg + tmm_pkg::K_W'(1)) == cfg_reg.k);
    assign out_free = !out_vld_reg || result.ready;

    assign result.valid        = out_vld_reg;
    assign result.rank         = out_rank_reg;
    assign result.distance_res = out_score_reg;
    assign result.label_res    = out_ident_reg;
    assign result.last_result  = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        cfg_next        = cfg_reg;
        scan_next       = scan_reg;
        cmp_vld_next    = 1'b0;
        cmp_use_next    = 1'b0;
        cmp_list_next   = scan_reg;
        found_next      = found_reg;
        best_list_next  = best_list_reg;
        best_score_next = best_score_reg;
        best_ident_next = best_ident_reg;
        emit_next       = emit_reg;
        head_next       = head_reg;
        out_vld_next    = out_vld_reg && !result.ready;
        out_rank_next   = out_rank_reg;
        out_score_next  = out_score_reg;
        out_ident_next  = out_ident_reg;
        out_last_next   = out_last_reg;

        // Fold the candidate read in the previous cycle into the best so far.
        if (cmp_vld_reg && cmp_use_reg)
        begin
            if (!found_reg || tmm_pkg::better(cfg_reg.metric_mode, rd_score, best_score_reg))
            begin
                found_next      = 1'b1;
                best_list_next  = cmp_list_reg;
                best_score_next = rd_score;
                best_ident_next = rd_ident;
            end
        end

        case (state_reg)
            tmm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cfg_next   = cfg;
                    scan_next  = '0;
                    found_next = 1'b0;
                    emit_next  = '0;
                    for (int i = 0; i < NHEAD; i++)
                    begin
                        head_next[i] = '0;
                    end
                    state_next = tmm_pkg::ST_SCAN;
                end
            end
            tmm_pkg::ST_SCAN:
            begin
                cmp_vld_next = 1'b1;
                cmp_use_next = (head_reg[scan_reg] < cfg_reg.k);
                if (tmm_pkg::LC_W'(scan_reg) == (cfg_reg.lc - tmm_pkg::LC_W'(1)))
                begin
                    state_next = tmm_pkg::ST_DRAIN;
                end
                else
                begin
                    scan_next = scan_reg + LIW'(1);
                end
            end
            tmm_pkg::ST_DRAIN:
            begin
                state_next = tmm_pkg::ST_PUT;
            end
            tmm_pkg::ST_PUT:
            begin
                if (!found_reg)
                begin
                    state_next = tmm_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    out_vld_next   = 1'b1;
                    out_rank_next  = emit_reg[tmm_pkg::RANK_W-1:0];
                    out_score_next = best_score_reg;
                    out_ident_next = best_ident_reg;
                    out_last_next  = is_last;
                    head_next[best_list_reg] = head_reg[best_list_reg] + tmm_pkg::K_W'(1);
                    emit_next  = emit_reg + tmm_pkg::K_W'(1);
                    scan_next  = '0;
                    found_next = 1'b0;
                    state_next = is_last ? tmm_pkg::ST_IDLE : tmm_pkg::ST_SCAN;
                end
            end
            default:
            begin
                state_next = tmm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tmm_pkg::ST_IDLE;
            cfg_reg     <= '0;
            scan_reg    <= '0;
            cmp_vld_reg <= 1'b0;
            cmp_use_reg <= 1'b0;
            found_reg   <= 1'b0;
            emit_reg    <= '0;
            out_vld_reg <= 1'b0;
            for (int i = 0; i < NHEAD; i++)
            begin
                head_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            cfg_reg     <= cfg_next;
            scan_reg    <= scan_next;
            cmp_vld_reg <= cmp_vld_next;
            cmp_use_reg <= cmp_use_next;
            found_reg   <= found_next;
            emit_reg    <= emit_next;
            out_vld_reg <= out_vld_next;
            head_reg    <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_list_reg   <= cmp_list_next;
        best_list_reg  <= best_list_next;
        best_score_reg <= best_score_next;
        best_ident_reg <= best_ident_next;
        out_rank_reg   <= out_rank_next;
        out_score_reg  <= out_score_next;
        out_ident_reg  <= out_ident_next;
        out_last_reg   <= out_last_next;
    end

endmodule

`default_nettype wire

// ----- rtl/topk_multiway_merge_top.sv -----
// ----------------------------------------------------------------------------
// topk_multiway_merge_top
// Merges up to MAX_LISTS sorted top-k lists of one query into one top-k list.
//
//   Channel  Direction  Handshake      Carries
//   entry    in         valid/ready    list_index, entry_position, distance,
//                                      label, last_entry
//   result   out        valid/ready    rank, distance_res, label_res,
//                                      last_result
//   cfg      in         cfg_we only    cfg_index, cfg_data
//
// Entries load at one item per cycle while no merge runs. An item with last_entry set
// starts the merge, and entry stays blocked until the last result sits in the output
// register. Each result takes one store read per list head on the shared read port
// (ST_SCAN), a last compare (ST_DRAIN) and an emit step (ST_PUT). A stalled output holds
// the merge in its emit step. Reset needs no clearing pass; the stores keep old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module topk_multiway_merge_top #(
    parameter int MAX_LISTS = tmm_pkg::MAX_LISTS_DEF,
    parameter int MAX_K     = tmm_pkg::MAX_K_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    tmm_entry_if.sink                               entry,
    tmm_result_if.source                            result,
    input  wire logic                               cfg_we,
    input  wire logic [tmm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tmm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int LIW    = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
    localparam int KPW    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int ADDR_W = LIW + KPW;
    localparam int DEPTH  = 1 << ADDR_W;

    logic                           metric_reg, metric_next;
    logic [tmm_pkg::K_W-1:0]        topk_reg, topk_next;
    logic [tmm_pkg::LISTS_W-1:0]    lists_reg, lists_next;
    tmm_pkg::tmm_merge_cfg_t        merge_cfg;
    logic [tmm_pkg::LC_W-1:0]       lists_wide;
    logic                           busy;
    logic                           accept;
    logic                           start;
    logic                           wr_en;
    logic [ADDR_W-1:0]              wr_addr;
    logic [ADDR_W-1:0]              rd_addr;
    logic [tmm_pkg::SCORE_W-1:0]    rd_score;
    logic [tmm_pkg::IDENT_W-1:0]    rd_ident;

    always_comb
    begin
        metric_next = metric_reg;
        topk_next   = topk_reg;
        lists_next  = lists_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                tmm_pkg::CFG_METRIC_MODE: metric_next = cfg_data[0];
                tmm_pkg::CFG_TOPK_COUNT:  topk_next   = cfg_data[tmm_pkg::K_W-1:0];
                tmm_pkg::CFG_LIST_COUNT:  lists_next  = cfg_data[tmm_pkg::LISTS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg <= 1'b0;
            topk_reg   <= tmm_pkg::K_W'(64);
            lists_reg  <= tmm_pkg::LISTS_W'(8);
        end
        else
        begin
            metric_reg <= metric_next;
            topk_reg   <= topk_next;
            lists_reg  <= lists_next;
        end
    end

    // Counts are clamped into their legal ranges before the merge uses them.
    assign lists_wide = tmm_pkg::LC_W'(lists_reg);

    always_comb
    begin
        merge_cfg.metric_mode = metric_reg;
        if (topk_reg == '0)
        begin
            merge_cfg.k = tmm_pkg::K_W'(1);
        end
        else if (topk_reg > tmm_pkg::K_W'(MAX_K))
        begin
            merge_cfg.k = tmm_pkg::K_W'(MAX_K);
        end
        else
        begin
            merge_cfg.k = topk_reg;
        end
        if (lists_wide == '0)
        begin
            merge_cfg.lc = tmm_pkg::LC_W'(1);
        end
        else if (lists_wide > tmm_pkg::LC_W'(MAX_LISTS))
        begin
            merge_cfg.lc = tmm_pkg::LC_W'(MAX_LISTS);
        end
        else
        begin
            merge_cfg.lc = lists_wide;
        end
    end

    assign entry.ready = !busy;
    assign accept      = entry.valid && !busy;
    assign start       = accept && entry.last_entry;

    // Entries outside the store are dropped, but still may start the merge.
    assign wr_en   = accept
                   && (32'(entry.list_index) < 32'(MAX_LISTS))
                   && (32'(entry.entry_position) < 32'(MAX_K));
    assign wr_addr = {LIW'(entry.list_index), KPW'(entry.entry_position)};

    tmm_ram #(
        .WIDTH (tmm_pkg::SCORE_W),
        .DEPTH (DEPTH)
    ) u_score_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (entry.distance),
        .raddr (rd_addr),
        .rdata (rd_score)
    );

    tmm_ram #(
        .WIDTH (tmm_pkg::IDENT_W),
        .DEPTH (DEPTH)
    ) u_ident_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (entry.label),
        .raddr (rd_addr),
        .rdata (rd_ident)
    );

    tmm_merge_ctrl #(
        .MAX_LISTS (MAX_LISTS),
        .MAX_K     (MAX_K)
    ) u_merge_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cfg      (merge_cfg),
        .busy     (busy),
        .rd_addr  (rd_addr),
        .rd_score (rd_score),
        .rd_ident (rd_ident),
        .result   (result)
    );

endmodule

`default_nettype wire
